### src/text_cell_renderer_top_macros.svh
// Assertion macros shared by the text cell renderer modules.
`ifndef TEXT_CELL_RENDERER_TOP_MACROS_SVH
`define TEXT_CELL_RENDERER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under synchronous active-low reset
`define TRC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under synchronous active-low reset
`define TRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TRC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define TRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/trc_pkg.sv
// Types and constants shared by the text cell renderer.
package trc_pkg;

    // Input action codes
    localparam logic [1:0] ACT_FONT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_FRAME_START = 2'd1;
    localparam logic [1:0] ACT_DISPLAY     = 2'd2;

    // Screen modes
    localparam logic MODE_COLLAPSED = 1'b0;
    localparam logic MODE_FULL      = 1'b1;

    // Line geometry and special codes
    localparam logic [7:0] BLANK_CODE     = 8'd118;
    localparam logic [6:0] COLLAPSED_COLS = 7'd33;
    localparam logic [6:0] FULL_COLS      = 7'd32;

    // Command queue geometry
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    typedef enum logic [1:0] {
        CMD_FONT,
        CMD_FRAME,
        CMD_CHAR,
        CMD_BLANK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [9:0] font_address;
        logic [7:0] font_data;
        logic [7:0] char_code;
    } t_cmd;

    typedef struct packed {
        logic [5:0]  cell_column;
        logic [4:0]  cell_row;
        logic [63:0] glyph_pixels;
        logic        last_of_run;
        logic        frame_end;
    } t_cell;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

endpackage

### src/trc_in_if.sv
// Input item channel of the text cell renderer.
interface trc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [9:0] font_address;
    logic [7:0] font_data;
    logic [7:0] char_code;

    modport source (output valid, output action, output font_address, output font_data,
                    output char_code, input ready);
    modport sink (input valid, input action, input font_address, input font_data,
                  input char_code, output ready);
endinterface

### src/trc_out_if.sv
// Result cell channel of the text cell renderer.
interface trc_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  cell_column;
    logic [4:0]  cell_row;
    logic [63:0] glyph_pixels;
    logic        last_of_run;
    logic        frame_end;

    modport source (output valid, output cell_column, output cell_row, output glyph_pixels,
                    output last_of_run, output frame_end, input ready);
    modport sink (input valid, input cell_column, input cell_row, input glyph_pixels,
                  input last_of_run, input frame_end, output ready);
endinterface

### src/trc_cfg_if.sv
// Configuration write channel of the text cell renderer.
interface trc_cfg_if;
    logic valid;
    logic ready;
    logic screen_mode;

    modport source (output valid, output screen_mode, input ready);
    modport sink (input valid, input screen_mode, output ready);
endinterface

### src/trc_front.sv
// Front end: accepts input items and classifies them into queue commands.
module trc_front
    import trc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_screen_mode,
    trc_in_if.sink i_in,
    input  logic   i_queue_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    logic keep;

    // Accept whenever the queue has room
    assign i_in.ready = !i_queue_full;

    // Classify the item; drop unused actions
    always_comb begin
        keep               = 1'b0;
        o_cmd.kind         = CMD_CHAR;
        o_cmd.font_address = i_in.font_address;
        o_cmd.font_data    = i_in.font_data;
        o_cmd.char_code    = i_in.char_code;
        unique case (i_in.action)
            ACT_FONT_WRITE: begin
                keep       = 1'b1;
                o_cmd.kind = CMD_FONT;
            end
            ACT_FRAME_START: begin
                keep       = 1'b1;
                o_cmd.kind = CMD_FRAME;
            end
            ACT_DISPLAY: begin
                keep = 1'b1;
                if (i_screen_mode == MODE_COLLAPSED && i_in.char_code == BLANK_CODE) begin
                    o_cmd.kind = CMD_BLANK;
                end else begin
                    o_cmd.kind = CMD_CHAR;
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_in.valid && !i_queue_full && keep;

    // Track a full queue refusing items (used only for the check below)
    logic r_stalled;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stalled <= 1'b0;
        end else begin
            r_stalled <= i_in.valid && i_queue_full;
        end
    end

    `include "text_cell_renderer_top_macros.svh"

    `TRC_ASSERT_IMPLY(a_no_push_when_full, i_clk, i_rst_n, i_queue_full, !o_push, "push into full queue")
    `TRC_ASSERT_IMPLY(a_stall_not_ready, i_clk, i_rst_n, r_stalled && i_queue_full, !i_in.ready, "ready while queue full")

endmodule

### src/trc_cmd_queue.sv
// Short command queue between the front end and the back end.
module trc_cmd_queue
    import trc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `include "text_cell_renderer_top_macros.svh"

    `TRC_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QDEPTH), "queue overflow")
    `TRC_ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")

endmodule

### src/trc_back.sv
// Back end: font store, cursor state and cell emission with an output register.
module trc_back
    import trc_pkg::*;
#(
    parameter int unsigned FONT_DEPTH = 1024,
    parameter int unsigned TEXT_ROWS  = 24
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_screen_mode,
    input  logic  i_cmd_valid,
    input  t_cmd  i_cmd,
    output logic  o_cmd_pop,
    output logic  o_cell_valid,
    input  logic  i_cell_ready,
    output t_cell o_cell
);

    localparam int unsigned FONT_ROWS  = (FONT_DEPTH + 7) / 8;
    localparam int unsigned ROW_AW     = $clog2(FONT_ROWS);
    localparam logic [10:0] FONT_LIMIT = 11'(FONT_DEPTH);
    localparam logic [7:0]  ROWS_LIMIT = 8'(FONT_ROWS);
    localparam logic [5:0]  ROW_LIMIT  = 6'(TEXT_ROWS);

    // Font store: one 64-bit glyph per row, byte-lane writes
    logic [63:0] r_font [FONT_ROWS];
    logic [63:0] r_rd_data;

    t_back_state r_state, n_state;
    logic [5:0]  r_col, n_col;
    logic [4:0]  r_row, n_row;
    logic        r_skip, n_skip;
    logic        r_done, n_done;
    logic [6:0]  r_glyph, n_glyph;
    logic        r_inv, n_inv;
    logic        r_blank, n_blank;
    logic        r_out_valid;
    t_cell       r_cell;

    logic        rd_en;
    logic        wr_en;
    logic        start;
    logic        load;
    logic [6:0]  rd_row;
    logic [6:0]  col_inc;
    logic        endline;
    logic        lastrow;
    logic        last;
    logic [63:0] pix;
    t_cell       emit_cell;

    // Cursor arithmetic for the cell in flight
    assign col_inc = {1'b0, r_col} + 7'd1;
    assign endline = col_inc >= ((i_screen_mode == MODE_FULL) ? FULL_COLS : COLLAPSED_COLS);
    assign lastrow = ({1'b0, r_row} + 6'd1) >= ROW_LIMIT;
    assign last    = !r_blank || endline;

    // Mask bytes beyond the font depth, then apply inversion
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if ({1'b0, r_glyph, 3'(i)} < FONT_LIMIT) begin
                pix[63-8*i -: 8] = r_rd_data[63-8*i -: 8] ^ {8{r_inv}};
            end else begin
                pix[63-8*i -: 8] = {8{r_inv}};
            end
        end
    end

    assign emit_cell.cell_column  = r_col;
    assign emit_cell.cell_row     = r_row;
    assign emit_cell.glyph_pixels = pix;
    assign emit_cell.last_of_run  = last;
    assign emit_cell.frame_end    = endline && lastrow;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (start) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (load && last) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Command execution and cursor updates
    always_comb begin
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        start     = 1'b0;
        load      = 1'b0;
        rd_row    = i_cmd.char_code[6:0];
        n_col     = r_col;
        n_row     = r_row;
        n_skip    = r_skip;
        n_done    = r_done;
        n_glyph   = r_glyph;
        n_inv     = r_inv;
        n_blank   = r_blank;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind) inside
                        CMD_FONT: begin
                            wr_en = ({1'b0, i_cmd.font_address} < FONT_LIMIT);
                        end
                        CMD_FRAME: begin
                            n_col  = '0;
                            n_row  = '0;
                            n_skip = 1'b0;
                            n_done = 1'b0;
                        end
                        CMD_CHAR, CMD_BLANK: begin
                            if (r_done) begin
                                // frame complete: drop until frame start
                            end else if (i_screen_mode == MODE_COLLAPSED && r_skip) begin
                                // drop the terminator after a full line
                                n_skip = 1'b0;
                            end else begin
                                start   = 1'b1;
                                rd_en   = 1'b1;
                                n_skip  = 1'b0;
                                n_blank = (i_cmd.kind == CMD_BLANK);
                                if (i_cmd.kind == CMD_BLANK) begin
                                    rd_row  = '0;
                                    n_glyph = '0;
                                    n_inv   = 1'b0;
                                end else begin
                                    n_glyph = i_cmd.char_code[6:0];
                                    n_inv   = (i_screen_mode == MODE_FULL) ?
                                              !i_cmd.char_code[7] : i_cmd.char_code[7];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_EMIT: begin
                if (!r_out_valid || i_cell_ready) begin
                    load  = 1'b1;
                    n_col = col_inc[5:0];
                    if (endline) begin
                        n_col = '0;
                        if (lastrow) begin
                            n_row  = '0;
                            n_done = 1'b1;
                        end else begin
                            n_row = r_row + 5'd1;
                        end
                        if (i_screen_mode == MODE_COLLAPSED && !r_blank && !lastrow) begin
                            n_skip = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Font store write and registered glyph read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_font[i_cmd.font_address[ROW_AW+2:3]][{~i_cmd.font_address[2:0], 3'b000} +: 8]
                <= i_cmd.font_data;
        end
        if (rd_en && ({1'b0, rd_row} < ROWS_LIMIT)) begin
            r_rd_data <= r_font[rd_row[ROW_AW-1:0]];
        end
    end

    // Control and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_skip  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_skip  <= n_skip;
            r_done  <= n_done;
        end
    end

    // Per-command payload
    always_ff @(posedge i_clk) begin
        r_glyph <= n_glyph;
        r_inv   <= n_inv;
        r_blank <= n_blank;
    end

    // Output register: load a cell when the slot is free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_cell_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cell <= emit_cell;
        end
    end

    assign o_cell_valid = r_out_valid;
    assign o_cell       = r_cell;

    `include "text_cell_renderer_top_macros.svh"

    `TRC_ASSERT_IMPLY(a_done_row_zero, i_clk, i_rst_n, r_done, r_row == '0, "row not cleared")
    `TRC_ASSERT_NEXT(a_frame_end_done, i_clk, i_rst_n, load && emit_cell.frame_end, r_done, "no done")
    `TRC_ASSERT_IMPLY(a_emit_no_skip, i_clk, i_rst_n, r_state == BK_EMIT, !r_skip, "skip in emit")

endmodule

### src/text_cell_renderer_top.sv
// Text cell renderer: front end, command queue, back end and configuration register.
// When the back end is idle, an accepted display byte passes the command queue and
// the font row read into the output register. The back end reads the font row, then
// emits the cell; a blank fill emits one cell per cycle unless the output stalls.
// The 4-entry command queue lets the input keep accepting while the back end is busy.
// Synchronous active-low reset clears cursor, queue, output valid and mode, not the font.
module text_cell_renderer_top
    import trc_pkg::*;
#(
    parameter int unsigned FONT_DEPTH = 1024,
    parameter int unsigned TEXT_ROWS  = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    trc_in_if.sink    i_in,
    trc_out_if.source o_out,
    trc_cfg_if.sink   i_cfg
);

    logic  r_screen_mode;
    logic  queue_full;
    logic  push;
    t_cmd  push_cmd;
    logic  cmd_valid;
    t_cmd  cmd;
    logic  cmd_pop;
    logic  cell_valid;
    t_cell back_cell;

    // Configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_mode <= MODE_COLLAPSED;
        end else if (i_cfg.valid) begin
            r_screen_mode <= i_cfg.screen_mode;
        end
    end

    trc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_screen_mode(r_screen_mode),
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    trc_cmd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (cmd_pop),
        .o_full (queue_full),
        .o_valid(cmd_valid),
        .o_cmd  (cmd)
    );

    trc_back #(
        .FONT_DEPTH(FONT_DEPTH),
        .TEXT_ROWS (TEXT_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_screen_mode(r_screen_mode),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_cell_valid (cell_valid),
        .i_cell_ready (o_out.ready),
        .o_cell       (back_cell)
    );

    // Drive the result channel
    assign o_out.valid        = cell_valid;
    assign o_out.cell_column  = back_cell.cell_column;
    assign o_out.cell_row     = back_cell.cell_row;
    assign o_out.glyph_pixels = back_cell.glyph_pixels;
    assign o_out.last_of_run  = back_cell.last_of_run;
    assign o_out.frame_end    = back_cell.frame_end;

endmodule
